>>> hdl/crl_pkg.sv
// ----------------------------------------------------------------------------
// crl_pkg: shared types and constants for the contig range lookup unit
// Opcodes, result status codes, controller states and the control word that
// travels along the chain of range cells.
// ----------------------------------------------------------------------------
package crl_pkg;

  localparam int MAX_RANGES_DEF = 256;
  localparam int COORD_BITS_DEF = 32;

  // Opcodes of an input beat.
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_LOAD   = 2'd1;
  localparam logic [1:0] OP_LCP    = 2'd2;
  localparam logic [1:0] OP_LOCATE = 2'd3;

  // Result status codes.
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_MISS = 2'd2;

  // Largest room value that fits in a result beat.
  localparam logic [31:0] ROOM_MAX = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_ROOM,
    ST_FINISH
  } crl_state_t;

  // Control word of a search token moving along the cell chain.
  typedef struct packed {
    logic valid;
    logic found;
  } crl_ctl_t;

endpackage

>>> hdl/crl_cell.sv
// ----------------------------------------------------------------------------
// crl_cell: one range cell of the lookup chain
// Holds the bounds of one contig and checks a passing search token against
// them. A token that has already hit passes through untouched, so the lowest
// index wins.
// ----------------------------------------------------------------------------
module crl_cell
  import crl_pkg::*;
#(
  parameter int MAX_RANGES = MAX_RANGES_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int CELL_IDX   = 0,
  localparam int IDX_W     = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1,
  localparam int CNT_W     = $clog2(MAX_RANGES + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [COORD_BITS-1:0] wr_first,
  input  logic [COORD_BITS-1:0] wr_last,
  input  logic [CNT_W-1:0]      range_count,
  input  crl_ctl_t              ctl_in,
  input  logic [COORD_BITS-1:0] pos_in,
  input  logic [IDX_W-1:0]      idx_in,
  input  logic [COORD_BITS-1:0] first_in,
  input  logic [COORD_BITS-1:0] last_in,
  output crl_ctl_t              ctl_out,
  output logic [COORD_BITS-1:0] pos_out,
  output logic [IDX_W-1:0]      idx_out,
  output logic [COORD_BITS-1:0] first_out,
  output logic [COORD_BITS-1:0] last_out
);

  logic [COORD_BITS-1:0] first_r, last_r;
  crl_ctl_t              ctl_r, ctl_nxt;
  logic [COORD_BITS-1:0] pos_r, pos_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [COORD_BITS-1:0] tfirst_r, tfirst_nxt;
  logic [COORD_BITS-1:0] tlast_r, tlast_nxt;
  logic                  live;
  logic                  hit;

  // Only cells below the fill count hold a loaded contig.
  assign live = range_count > CNT_W'(CELL_IDX);
  assign hit  = ctl_in.valid && !ctl_in.found && live &&
                (pos_in >= first_r) && (pos_in <= last_r);

  always_comb begin
    ctl_nxt.valid = ctl_in.valid;
    ctl_nxt.found = ctl_in.found | hit;
    pos_nxt       = pos_in;
    idx_nxt       = hit ? IDX_W'(CELL_IDX) : idx_in;
    tfirst_nxt    = hit ? first_r : first_in;
    tlast_nxt     = hit ? last_r : last_in;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      first_r <= wr_first;
      last_r  <= wr_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    idx_r    <= idx_nxt;
    tfirst_r <= tfirst_nxt;
    tlast_r  <= tlast_nxt;
  end

  assign ctl_out   = ctl_r;
  assign pos_out   = pos_r;
  assign idx_out   = idx_r;
  assign first_out = tfirst_r;
  assign last_out  = tlast_r;

endmodule

>>> hdl/contig_range_lookup_lcp_clamp_unit.sv
// ----------------------------------------------------------------------------
// contig_range_lookup_lcp_clamp_unit: contig range table with LCP clamping
// Clears and appends contig ranges, locates the contig holding a position and clamps
// suffix array LCP values to the room left in the current and previous
// entries' contigs.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake            Payload
//   -------   ------------------   ------------------------------------------
//   input     start & !busy        in_opcode .. in_first_entry
//   result    out_valid (strobe)   out_clamped_lcp .. out_status
//
// A clear or load beat gives its result in the cycle after it is taken, and
// the next beat can be taken in that same cycle. A locate or LCP beat sends a
// search token down the chain of MAX_RANGES range cells, one cell per cycle,
// then works out the room in ST_ROOM and the clamp in ST_FINISH, and its result
// strobes from the result registers after that, with busy high until then.
// Reset is synchronous and active low; it empties the table and the previous
// entry state. The receiver cannot stall: each result shows for one cycle.
//
module contig_range_lookup_lcp_clamp_unit
  import crl_pkg::*;
#(
  parameter int MAX_RANGES = MAX_RANGES_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_contig_length,
  input  logic        in_new_group,
  input  logic [31:0] in_group_offset,
  input  logic [31:0] in_position,
  input  logic [31:0] in_lcp_value,
  input  logic        in_is_separator,
  input  logic        in_first_entry,
  output logic        out_valid,
  output logic [31:0] out_clamped_lcp,
  output logic [7:0]  out_contig_index,
  output logic [31:0] out_region_start,
  output logic [31:0] out_region_end,
  output logic [1:0]  out_status
);

  localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CNT_W = $clog2(MAX_RANGES + 1);
  localparam logic [COORD_BITS+32:0] ROOM_CAP = {{(COORD_BITS + 1){1'b0}}, ROOM_MAX};
  localparam logic [COORD_BITS+32:0] DIST_ONE = {{(COORD_BITS + 32){1'b0}}, 1'b1};

  crl_state_t state_r, state_nxt;

  logic accept;
  assign accept = start && !busy;

  // Input coordinates taken modulo 2^COORD_BITS.
  logic [COORD_BITS+31:0] goff_w, pos_w, len_w;
  logic [COORD_BITS-1:0]  goff_c, pos_c, len_c;
  assign goff_w = {{COORD_BITS{1'b0}}, in_group_offset};
  assign pos_w  = {{COORD_BITS{1'b0}}, in_position};
  assign len_w  = {{COORD_BITS{1'b0}}, in_contig_length};
  assign goff_c = goff_w[COORD_BITS-1:0];
  assign pos_c  = pos_w[COORD_BITS-1:0];
  assign len_c  = len_w[COORD_BITS-1:0];

  // Table bookkeeping and previous LCP entry.
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [COORD_BITS-1:0] last_end_r, last_end_nxt;
  logic [31:0]           prev_room_r, prev_room_nxt;
  logic                  prev_sep_r, prev_sep_nxt;
  logic                  prev_ok_r, prev_ok_nxt;

  // Item held during a search.
  logic [1:0]  op_r;
  logic [31:0] lcp_r;
  logic        sep_r;
  logic        first_ent_r;

  // Token captured at the chain tail.
  logic                  found_r;
  logic [IDX_W-1:0]      idx_r;
  logic [COORD_BITS-1:0] rfirst_r, rlast_r, dist_r;
  logic [31:0]           room_r, room_nxt;

  // Result registers.
  logic        res_valid_r, res_valid_nxt;
  logic [31:0] res_lcp_r, res_lcp_nxt;
  logic [7:0]  res_idx_r, res_idx_nxt;
  logic [31:0] res_start_r, res_start_nxt;
  logic [31:0] res_end_r, res_end_nxt;
  logic [1:0]  res_status_r, res_status_nxt;

  // ---------------------------------------------------------------- load path
  logic                  table_full;
  logic                  load_we;
  logic [IDX_W-1:0]      wr_idx;
  logic [COORD_BITS-1:0] load_start, load_end;

  assign table_full = count_r == CNT_W'(MAX_RANGES);
  assign load_we    = accept && (in_opcode == OP_LOAD) && !table_full;
  assign wr_idx     = count_r[IDX_W-1:0];
  assign load_start = (in_new_group || count_r == '0) ? goff_c
                                                     : last_end_r + COORD_BITS'(2);
  assign load_end   = load_start + len_c - COORD_BITS'(1);

  // --------------------------------------------------------------- cell chain
  crl_ctl_t              ctl_c   [MAX_RANGES+1];
  logic [COORD_BITS-1:0] cpos_c  [MAX_RANGES+1];
  logic [IDX_W-1:0]      cidx_c  [MAX_RANGES+1];
  logic [COORD_BITS-1:0] cfirst_c[MAX_RANGES+1];
  logic [COORD_BITS-1:0] clast_c [MAX_RANGES+1];

  assign ctl_c[0].valid = accept && (in_opcode == OP_LCP || in_opcode == OP_LOCATE);
  assign ctl_c[0].found = 1'b0;
  assign cpos_c[0]      = pos_c;
  assign cidx_c[0]      = '0;
  assign cfirst_c[0]    = '0;
  assign clast_c[0]     = '0;

  for (genvar g = 0; g < MAX_RANGES; g++) begin : g_cell
    logic cell_we;
    assign cell_we = load_we && (wr_idx == IDX_W'(g));

    crl_cell #(
      .MAX_RANGES(MAX_RANGES),
      .COORD_BITS(COORD_BITS),
      .CELL_IDX  (g)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .wr_en      (cell_we),
      .wr_first   (load_start),
      .wr_last    (load_end),
      .range_count(count_r),
      .ctl_in     (ctl_c[g]),
      .pos_in     (cpos_c[g]),
      .idx_in     (cidx_c[g]),
      .first_in   (cfirst_c[g]),
      .last_in    (clast_c[g]),
      .ctl_out    (ctl_c[g+1]),
      .pos_out    (cpos_c[g+1]),
      .idx_out    (cidx_c[g+1]),
      .first_out  (cfirst_c[g+1]),
      .last_out   (clast_c[g+1])
    );
  end

  crl_ctl_t tail_ctl;
  assign tail_ctl = ctl_c[MAX_RANGES];

  // -------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (ctl_c[0].valid) begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (tail_ctl.valid) begin
          state_nxt = ST_ROOM;
        end
      end
      ST_ROOM:   state_nxt = ST_FINISH;
      ST_FINISH: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // ------------------------------------------------------------------ outputs
  logic [COORD_BITS+32:0] dist_w, dist_inc;
  logic                   found_eff;
  logic [31:0]            room_eff, clamp_a, clamp_b;
  logic [IDX_W+7:0]       idx_w;
  logic [COORD_BITS+31:0] rfirst_w, rlast_w, start_w, end_w;

  assign dist_w   = {{33{1'b0}}, dist_r};
  assign dist_inc = dist_w + DIST_ONE;
  assign room_nxt = (dist_w >= ROOM_CAP) ? ROOM_MAX : dist_inc[31:0];

  assign found_eff = found_r && !sep_r;
  assign room_eff  = found_eff ? room_r : '0;
  assign clamp_a   = (lcp_r < room_r) ? lcp_r : room_r;
  assign clamp_b   = (prev_room_r < clamp_a) ? prev_room_r : clamp_a;

  assign idx_w    = {8'b0, idx_r};
  assign rfirst_w = {32'b0, rfirst_r};
  assign rlast_w  = {32'b0, rlast_r};
  assign start_w  = {32'b0, load_start};
  assign end_w    = {32'b0, load_end};

  // Low eight bits of the fill count, as the index of a new contig.
  function automatic logic [7:0] wr_idx_byte(input logic [CNT_W-1:0] cnt);
    logic [CNT_W+7:0] wide;
    wide = {8'b0, cnt};
    return wide[7:0];
  endfunction

  always_comb begin
    busy           = state_r != ST_IDLE;
    count_nxt      = count_r;
    last_end_nxt   = last_end_r;
    prev_room_nxt  = prev_room_r;
    prev_sep_nxt   = prev_sep_r;
    prev_ok_nxt    = prev_ok_r;
    res_valid_nxt  = 1'b0;
    res_lcp_nxt    = '0;
    res_idx_nxt    = '0;
    res_start_nxt  = '0;
    res_end_nxt    = '0;
    res_status_nxt = STAT_OK;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_opcode == OP_CLEAR) begin
          res_valid_nxt = 1'b1;
          count_nxt     = '0;
          prev_room_nxt = '0;
          prev_sep_nxt  = 1'b0;
          prev_ok_nxt   = 1'b0;
        end else if (accept && in_opcode == OP_LOAD) begin
          res_valid_nxt = 1'b1;
          if (table_full) begin
            res_status_nxt = STAT_FULL;
          end else begin
            count_nxt     = count_r + CNT_W'(1);
            last_end_nxt  = load_end;
            res_idx_nxt   = wr_idx_byte(count_r);
            res_start_nxt = start_w[31:0];
            res_end_nxt   = end_w[31:0];
          end
        end
      end
      ST_FINISH: begin
        res_valid_nxt = 1'b1;
        if (op_r == OP_LOCATE) begin
          if (found_r) begin
            res_idx_nxt   = idx_w[7:0];
            res_start_nxt = rfirst_w[31:0];
            res_end_nxt   = rlast_w[31:0];
          end else begin
            res_status_nxt = STAT_MISS;
          end
        end else begin
          if (lcp_r != '0 && !sep_r) begin
            if (!found_eff) begin
              res_status_nxt = STAT_MISS;
            end else if (first_ent_r) begin
              res_lcp_nxt = clamp_a;
            end else if (prev_sep_r) begin
              res_lcp_nxt = '0;
            end else if (!prev_ok_r) begin
              res_status_nxt = STAT_MISS;
            end else begin
              res_lcp_nxt = clamp_b;
            end
          end
          prev_sep_nxt  = sep_r;
          prev_ok_nxt   = found_eff;
          prev_room_nxt = room_eff;
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      prev_room_r <= '0;
      prev_sep_r  <= 1'b0;
      prev_ok_r   <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      prev_room_r <= prev_room_nxt;
      prev_sep_r  <= prev_sep_nxt;
      prev_ok_r   <= prev_ok_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_end_r   <= last_end_nxt;
    res_lcp_r    <= res_lcp_nxt;
    res_idx_r    <= res_idx_nxt;
    res_start_r  <= res_start_nxt;
    res_end_r    <= res_end_nxt;
    res_status_r <= res_status_nxt;
    if (accept) begin
      op_r        <= in_opcode;
      lcp_r       <= in_lcp_value;
      sep_r       <= in_is_separator;
      first_ent_r <= in_first_entry;
    end
    if (state_r == ST_SEARCH && tail_ctl.valid) begin
      found_r  <= tail_ctl.found;
      idx_r    <= cidx_c[MAX_RANGES];
      rfirst_r <= cfirst_c[MAX_RANGES];
      rlast_r  <= clast_c[MAX_RANGES];
      dist_r   <= clast_c[MAX_RANGES] - cpos_c[MAX_RANGES];
    end
    if (state_r == ST_ROOM) begin
      room_r <= room_nxt;
    end
  end

  assign out_valid        = res_valid_r;
  assign out_clamped_lcp  = res_lcp_r;
  assign out_contig_index = res_idx_r;
  assign out_region_start = res_start_r;
  assign out_region_end   = res_end_r;
  assign out_status       = res_status_r;

  // --------------------------------------------------------------- assertions
  a_tail_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    tail_ctl.valid |-> state_r == ST_SEARCH)
    else $error("search token left the chain outside a search");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_RANGES))
    else $error("contig count beyond table size");

  a_finish_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FINISH |=> out_valid && state_r == ST_IDLE)
    else $error("search finished without a result beat");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_opcode == OP_LOAD && table_full |=> out_valid && out_status == STAT_FULL)
    else $error("load into a full table not reported");

endmodule

>>> tb/contig_reply_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// contig_reply_checker: result predictor and comparator for the range unit
// Watches the command and result channels of the contig range lookup unit.
// Every accepted command beat updates a private copy of the contig table and
// of the previous suffix array entry, and queues the reply it must produce.
// Each result beat is compared field by field with the oldest queued reply.
// ----------------------------------------------------------------------------
module contig_reply_checker
  import crl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_contig_length,
  input  logic        in_new_group,
  input  logic [31:0] in_group_offset,
  input  logic [31:0] in_position,
  input  logic [31:0] in_lcp_value,
  input  logic        in_is_separator,
  input  logic        in_first_entry,
  input  logic        out_valid,
  input  logic [31:0] out_clamped_lcp,
  input  logic [7:0]  out_contig_index,
  input  logic [31:0] out_region_start,
  input  logic [31:0] out_region_end,
  input  logic [1:0]  out_status,
  output int          fail_count,
  output int          pending
);

  localparam int MAX_CONTIGS = MAX_RANGES_DEF;

  typedef struct {
    logic [31:0] clamped_lcp;
    logic [7:0]  contig_index;
    logic [31:0] region_start;
    logic [31:0] region_end;
    logic [1:0]  status;
  } contig_reply_t;

  logic [31:0]   contig_first [MAX_CONTIGS];
  logic [31:0]   contig_last  [MAX_CONTIGS];
  int            loaded_contigs = 0;
  logic [31:0]   prev_room      = '0;
  logic          prev_sep       = 1'b0;
  logic          prev_found     = 1'b0;

  contig_reply_t awaited_replies[$];
  int            mismatches  = 0;
  int            outstanding = 0;

  assign fail_count = mismatches;
  assign pending    = outstanding;

  task automatic note_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Lowest-index contig holding pos, or -1.
  function automatic int find_contig(input logic [31:0] pos);
    for (int i = 0; i < loaded_contigs; i++) begin
      if (pos >= contig_first[i] && pos <= contig_last[i]) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic contig_reply_t predict_reply(
    input logic [1:0]  op,
    input logic [31:0] len,
    input logic        new_group,
    input logic [31:0] goff,
    input logic [31:0] pos,
    input logic [31:0] lcp,
    input logic        sep,
    input logic        first
  );
    contig_reply_t r;
    logic [31:0]   from;
    logic [31:0]   span_left;
    logic [31:0]   room;
    logic [31:0]   clamp;
    int            hit;
    r = '{clamped_lcp: '0, contig_index: '0, region_start: '0, region_end: '0,
          status: STAT_OK};
    case (op)
      OP_CLEAR: begin
        loaded_contigs = 0;
        prev_room      = '0;
        prev_sep       = 1'b0;
        prev_found     = 1'b0;
      end
      OP_LOAD: begin
        if (loaded_contigs >= MAX_CONTIGS) begin
          r.status = STAT_FULL;
        end else begin
          // A chained contig leaves one separator symbol after its neighbor.
          from = (new_group || loaded_contigs == 0) ? goff
                 : contig_last[loaded_contigs - 1] + 32'd2;
          contig_first[loaded_contigs] = from;
          contig_last[loaded_contigs]  = from + len - 32'd1;
          r.contig_index = loaded_contigs[7:0];
          r.region_start = from;
          r.region_end   = contig_last[loaded_contigs];
          loaded_contigs++;
        end
      end
      OP_LOCATE: begin
        hit = find_contig(pos);
        if (hit < 0) begin
          r.status = STAT_MISS;
        end else begin
          r.contig_index = hit[7:0];
          r.region_start = contig_first[hit];
          r.region_end   = contig_last[hit];
        end
      end
      OP_LCP: begin
        hit  = -1;
        room = '0;
        if (!sep) begin
          hit = find_contig(pos);
          if (hit >= 0) begin
            span_left = contig_last[hit] - pos;
            room = (span_left == ROOM_MAX) ? ROOM_MAX : span_left + 32'd1;
          end
        end
        if (lcp != 0 && !sep) begin
          if (hit < 0) begin
            r.status = STAT_MISS;
          end else begin
            clamp = (lcp < room) ? lcp : room;
            if (!first) begin
              if (prev_sep) begin
                clamp = '0;
              end else if (!prev_found) begin
                clamp    = '0;
                r.status = STAT_MISS;
              end else if (prev_room < clamp) begin
                clamp = prev_room;
              end
            end
            r.clamped_lcp = clamp;
          end
        end
        prev_sep   = sep;
        prev_found = (hit >= 0);
        prev_room  = (hit >= 0) ? room : '0;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    contig_reply_t want;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (awaited_replies.size() == 0) begin
          note_mismatch("result beat with no reply expected");
        end else begin
          want = awaited_replies.pop_front();
          if (out_clamped_lcp !== want.clamped_lcp)
            note_mismatch($sformatf("clamped_lcp %h, expected %h",
                                    out_clamped_lcp, want.clamped_lcp));
          if (out_contig_index !== want.contig_index)
            note_mismatch($sformatf("contig_index %h, expected %h",
                                    out_contig_index, want.contig_index));
          if (out_region_start !== want.region_start)
            note_mismatch($sformatf("region_start %h, expected %h",
                                    out_region_start, want.region_start));
          if (out_region_end !== want.region_end)
            note_mismatch($sformatf("region_end %h, expected %h",
                                    out_region_end, want.region_end));
          if (out_status !== want.status)
            note_mismatch($sformatf("status %h, expected %h", out_status, want.status));
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        awaited_replies.insert(awaited_replies.size(),
                               predict_reply(in_opcode, in_contig_length, in_new_group,
                                             in_group_offset, in_position, in_lcp_value,
                                             in_is_separator, in_first_entry));
      end
    end
    outstanding <= awaited_replies.size();
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: top level test of the contig range lookup and LCP clamp unit
// Drives a directed opening (table edges, wrapped bounds, every clamp rule),
// then random groups of table loads, locates and suffix array runs, a pass
// that overfills the table, and random command noise, under several sender
// idle rates. The checker beside the unit predicts and compares every beat.
// ----------------------------------------------------------------------------
module tb;
  import crl_pkg::*;

  localparam int  TOTAL_BEATS  = 1750;
  localparam int  PHASE_BEATS  = 250;
  localparam int  DRAIN_CYCLES = MAX_RANGES_DEF + 16;
  localparam real LIMIT_NS     = 5000000.0;

  logic        clk              = 1'b0;
  logic        rst_n            = 1'b0;
  logic        start            = 1'b0;
  logic [1:0]  in_opcode        = OP_CLEAR;
  logic [31:0] in_contig_length = '0;
  logic        in_new_group     = 1'b0;
  logic [31:0] in_group_offset  = '0;
  logic [31:0] in_position      = '0;
  logic [31:0] in_lcp_value     = '0;
  logic        in_is_separator  = 1'b0;
  logic        in_first_entry   = 1'b0;
  logic        busy;
  logic        out_valid;
  logic [31:0] out_clamped_lcp;
  logic [7:0]  out_contig_index;
  logic [31:0] out_region_start;
  logic [31:0] out_region_end;
  logic [1:0]  out_status;
  int          fail_count;
  int          pending;

  int          beats_sent      = 0;
  int          sender_idle_pct = 0;

  always #1 clk = ~clk;

  contig_range_lookup_lcp_clamp_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_contig_length (in_contig_length),
    .in_new_group     (in_new_group),
    .in_group_offset  (in_group_offset),
    .in_position      (in_position),
    .in_lcp_value     (in_lcp_value),
    .in_is_separator  (in_is_separator),
    .in_first_entry   (in_first_entry),
    .out_valid        (out_valid),
    .out_clamped_lcp  (out_clamped_lcp),
    .out_contig_index (out_contig_index),
    .out_region_start (out_region_start),
    .out_region_end   (out_region_end),
    .out_status       (out_status)
  );

  contig_reply_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_contig_length (in_contig_length),
    .in_new_group     (in_new_group),
    .in_group_offset  (in_group_offset),
    .in_position      (in_position),
    .in_lcp_value     (in_lcp_value),
    .in_is_separator  (in_is_separator),
    .in_first_entry   (in_first_entry),
    .out_valid        (out_valid),
    .out_clamped_lcp  (out_clamped_lcp),
    .out_contig_index (out_contig_index),
    .out_region_start (out_region_start),
    .out_region_end   (out_region_end),
    .out_status       (out_status),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  // Holds start high until the beat is taken. Start is only lowered in an
  // idle cycle, so a back-to-back beat never sees it drop and rise in one step.
  task automatic drive_beat(
    input logic [1:0]  op,
    input logic [31:0] len,
    input logic        new_group,
    input logic [31:0] goff,
    input logic [31:0] pos,
    input logic [31:0] lcp,
    input logic        sep,
    input logic        first
  );
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start            <= 1'b1;
    in_opcode        <= op;
    in_contig_length <= len;
    in_new_group     <= new_group;
    in_group_offset  <= goff;
    in_position      <= pos;
    in_lcp_value     <= lcp;
    in_is_separator  <= sep;
    in_first_entry   <= first;
    do @(posedge clk); while (busy);
    beats_sent++;
  endtask

  task automatic clear_table();
    drive_beat(OP_CLEAR, $urandom, 1'($urandom_range(1)), $urandom, $urandom, $urandom,
               1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  task automatic load_contig(input logic [31:0] len, input logic new_group,
                             input logic [31:0] goff);
    drive_beat(OP_LOAD, len, new_group, goff, $urandom, $urandom,
               1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  task automatic locate_pos(input logic [31:0] pos);
    drive_beat(OP_LOCATE, $urandom, 1'($urandom_range(1)), $urandom, pos, $urandom,
               1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  task automatic lcp_entry(input logic [31:0] pos, input logic [31:0] lcp,
                           input logic sep, input logic first);
    drive_beat(OP_LCP, $urandom, 1'($urandom_range(1)), $urandom, pos, lcp, sep, first);
  endtask

  // The sender stays quiet until every queued reply has come back.
  task automatic wait_for_drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [31:0] pick_length();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return $urandom_range(1, 40);
    if (roll < 80) return '0;
    if (roll < 90) return $urandom;
    return $urandom_range(41, 1000);
  endfunction

  function automatic logic [31:0] pick_lcp();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return '0;
    if (roll < 25) return $urandom;
    if (roll < 35) return 32'hFFFF_FFFF;
    return $urandom_range(1, 40);
  endfunction

  // One group: a few chained contigs in a window, then a suffix array run
  // with locates mixed in. Some groups are a single random command instead.
  task automatic run_group();
    logic [31:0] lo;
    logic [31:0] span;
    logic [31:0] len;
    logic [31:0] pos;
    int          n_load;
    int          n_entry;
    if ($urandom_range(99) < 15) begin
      drive_beat(2'($urandom_range(3)), $urandom, 1'($urandom_range(1)), $urandom,
                 $urandom, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)));
      return;
    end
    if ($urandom_range(3) != 0) clear_table();
    lo     = $urandom;
    span   = '0;
    n_load = $urandom_range(1, 6);
    for (int i = 0; i < n_load; i++) begin
      len = pick_length();
      if (i == 0) begin
        load_contig(len, $urandom_range(4) != 0, lo);
      end else if ($urandom_range(4) == 0) begin
        span = span + $urandom_range(0, 6);
        load_contig(len, 1'b1, lo + span);
      end else begin
        load_contig(len, 1'b0, $urandom);
      end
      span = span + len + 32'd1;
    end
    n_entry = $urandom_range(3, 12);
    for (int i = 0; i < n_entry; i++) begin
      pos = ($urandom_range(9) == 0) ? $urandom : lo + $urandom_range(0, span + 2);
      if ($urandom_range(4) == 0) begin
        locate_pos(pos);
      end else begin
        lcp_entry(pos, pick_lcp(), $urandom_range(9) == 0,
                  i == 0 || $urandom_range(19) == 0);
      end
    end
  endtask

  // Loads past the table's capacity, then searches across all of it.
  task automatic fill_table();
    logic [31:0] lo;
    logic [31:0] span;
    logic [31:0] len;
    clear_table();
    lo   = $urandom_range(0, 32'hFFF0_0000);
    span = '0;
    for (int i = 0; i < MAX_RANGES_DEF + 3; i++) begin
      len = $urandom_range(1, 3);
      load_contig(len, i == 0, (i == 0) ? lo : $urandom);
      span = span + len + 32'd1;
    end
    for (int i = 0; i < 16; i++) begin
      if (i % 2 == 0) begin
        locate_pos(lo + $urandom_range(0, span + 2));
      end else begin
        lcp_entry(lo + $urandom_range(0, span + 2), pick_lcp(), 1'b0, i == 1);
      end
    end
  endtask

  initial begin
    #(LIMIT_NS);
    $display("contig_range_lookup_lcp_clamp_unit test failed");
    $finish;
  end

  initial begin
    int phase;
    int phase_end;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening, sender never idle.
    load_contig(32'd50, 1'b0, 32'd100);             // empty table, no new group
    lcp_entry(32'd110, 32'd5, 1'b0, 1'b0);          // no previous entry since reset
    load_contig(32'd1, 1'b0, $urandom);             // chained after a separator
    load_contig(32'd0, 1'b1, 32'd1000);             // zero length, empty range
    load_contig(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FF00); // last coordinate wraps
    load_contig(32'd256, 1'b0, $urandom);           // ends at the top coordinate
    locate_pos(32'd100);
    locate_pos(32'd149);
    locate_pos(32'd150);                            // separator gap
    locate_pos(32'hFFFF_FFFF);
    locate_pos(32'd0);
    lcp_entry(32'd100, 32'hFFFF_FFFF, 1'b0, 1'b1);  // clamped by own room
    lcp_entry(32'd140, 32'd20, 1'b0, 1'b0);
    lcp_entry(32'd120, 32'd0, 1'b0, 1'b0);          // zero LCP
    lcp_entry(32'd151, 32'd9, 1'b1, 1'b0);          // separator entry
    lcp_entry(32'd130, 32'd9, 1'b0, 1'b0);          // previous was a separator
    lcp_entry(32'd150, 32'd3, 1'b0, 1'b1);          // current in no contig
    lcp_entry(32'd101, 32'd7, 1'b0, 1'b0);          // previous in no contig
    lcp_entry(32'hFFFF_FFF0, 32'd40, 1'b0, 1'b0);   // clamped by own room
    clear_table();
    lcp_entry(32'd5, 32'd5, 1'b0, 1'b0);
    load_contig(32'd0, 1'b1, 32'd0);                // covers every coordinate
    lcp_entry(32'd0, 32'hFFFF_FFFF, 1'b0, 1'b1);    // room saturates
    clear_table();
    wait_for_drain();

    phase = 0;
    while (beats_sent < TOTAL_BEATS) begin
      case (phase % 3)
        0:       sender_idle_pct = 0;
        1:       sender_idle_pct = 76;
        default: sender_idle_pct = 30;
      endcase
      phase_end = beats_sent + PHASE_BEATS;
      if (phase == 2) fill_table();
      while (beats_sent < phase_end && beats_sent < TOTAL_BEATS) run_group();
      wait_for_drain();
      phase++;
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("contig_range_lookup_lcp_clamp_unit test passed");
    end else begin
      $display("contig_range_lookup_lcp_clamp_unit test failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/crl_pkg.sv
hdl/crl_cell.sv
hdl/contig_range_lookup_lcp_clamp_unit.sv
tb/contig_reply_checker.sv
tb/tb.sv
